// ===== rtl/core/assert_macros.svh =====
// Assertion helpers, clocked on clk_i and disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante holds at an edge -> cons holds at the same edge
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// cond must never hold at an edge
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// ===== rtl/core/uqpd_pkg.sv =====
package uqpd_pkg;

  typedef enum logic [1:0] {
    KIND_NAME     = 2'd0,
    KIND_VALUE    = 2'd1,
    KIND_PAIR_END = 2'd2,
    KIND_EOS      = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ESC_IDLE   = 2'd0,
    ESC_FIRST  = 2'd1,
    ESC_SECOND = 2'd2
  } esc_e;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_NAME_LIMIT  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_VALUE_LIMIT = 2'd1;

  localparam logic [7:0] NAME_LIMIT_RST  = 8'd31;
  localparam logic [7:0] VALUE_LIMIT_RST = 8'd63;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [4:0] NOT_HEX = 5'd16;

  // hex digit value, or NOT_HEX
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
    end else begin
      return NOT_HEX;
    end
    return {1'b0, d[3:0]};
  endfunction

  // escape byte from the two raw bytes after '%'
  function automatic logic [7:0] esc_byte(input logic [7:0] c0, input logic [7:0] c1);
    logic [4:0] h0;
    logic [4:0] h1;
    h0 = hex_digit(c0);
    h1 = hex_digit(c1);
    if (h0 == NOT_HEX) begin
      return 8'h00;
    end else if (h1 == NOT_HEX) begin
      return {4'h0, h0[3:0]};
    end
    return {h0[3:0], h1[3:0]};
  endfunction

endpackage

// ===== rtl/core/uqpd_ifs.sv =====
interface uqpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

interface uqpd_out_if;
  logic              valid;
  logic              ready;
  uqpd_pkg::kind_e   kind;
  logic [7:0]        char_out;
  logic [1:0]        status;
  logic [7:0]        name_count;
  logic [7:0]        value_count;

  modport source (output valid, output kind, output char_out, output status,
                  output name_count, output value_count, input ready);
  modport sink   (input valid, input kind, input char_out, input status,
                  input name_count, input value_count, output ready);
endinterface

// ===== rtl/core/url_query_param_decoder_unit.sv =====
// URL query decoder. Query text enters on in_i, one byte per beat; a zero
// byte ends the text. Each beat yields zero or one result beat on out_o:
// a decoded name byte, a decoded value byte, a pair end carrying overflow
// status and kept counts, or an end-of-string marker.
// Limits are written on the cfg port (index 0 name limit, 1 value limit);
// the user must do so while no beat is in flight, unchecked by the block.
// Path: a byte accepted into the input register is decoded by the single
// decode stage and its result is registered in the result register.
// Throughput: one byte per cycle while out_o is not stalled.
// Back-pressure: while out_o is stalled the result is held, the input
// register holds one more byte, and in_i.ready then drops.
// Reset: pair state is cleared (name phase, no escape pending), the
// limits return to 31 and 63, and both registers are emptied.
`include "assert_macros.svh"

module url_query_param_decoder_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [uqpd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [7:0]                    cfg_data_i,
  uqpd_in_if.sink                       in_i,
  uqpd_out_if.source                    out_o
);

  logic [7:0] name_limit_q, value_limit_q;

  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       out_free, s1_fire, in_fire;

  logic            in_value_q, in_value_d;
  uqpd_pkg::esc_e  esc_q, esc_d;
  logic [7:0]      first_q, first_d;
  logic [7:0]      name_kept_q, name_kept_d;
  logic [7:0]      value_kept_q, value_kept_d;
  logic            name_ovf_q, name_ovf_d;
  logic            value_ovf_q, value_ovf_d;
  logic            started_q, started_d;

  logic            out_valid_q;
  uqpd_pkg::kind_e out_kind_q;
  logic [7:0]      out_char_q, out_ncnt_q, out_vcnt_q;
  logic [1:0]      out_status_q;

  logic            res_valid;
  uqpd_pkg::kind_e res_kind;
  logic [7:0]      res_char, res_ncnt, res_vcnt;
  logic [1:0]      res_status;
  logic            emit, pair_end, clear;
  logic [7:0]      emit_ch;

  assign out_free = !out_valid_q || out_o.ready;
  assign s1_fire  = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;
  assign in_fire  = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_limit_q  <= uqpd_pkg::NAME_LIMIT_RST;
      value_limit_q <= uqpd_pkg::VALUE_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        uqpd_pkg::CFG_NAME_LIMIT:  name_limit_q  <= cfg_data_i;
        uqpd_pkg::CFG_VALUE_LIMIT: value_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= in_i.byte_in;
    end
  end

  // decode stage
  always_comb begin
    in_value_d   = in_value_q;
    esc_d        = esc_q;
    first_d      = first_q;
    name_kept_d  = name_kept_q;
    value_kept_d = value_kept_q;
    name_ovf_d   = name_ovf_q;
    value_ovf_d  = value_ovf_q;
    started_d    = started_q;
    res_valid    = 1'b0;
    res_kind     = uqpd_pkg::KIND_NAME;
    res_char     = 8'h00;
    res_status   = 2'b00;
    res_ncnt     = 8'h00;
    res_vcnt     = 8'h00;
    emit         = 1'b0;
    emit_ch      = 8'h00;
    pair_end     = 1'b0;
    clear        = 1'b0;

    if (s1_fire) begin
      if (s1_byte_q == uqpd_pkg::CH_NUL) begin
        clear = 1'b1;
        if (started_q) begin
          pair_end = 1'b1;
        end else begin
          res_valid = 1'b1;
          res_kind  = uqpd_pkg::KIND_EOS;
        end
      end else if (esc_q == uqpd_pkg::ESC_FIRST) begin
        first_d = s1_byte_q;
        esc_d   = uqpd_pkg::ESC_SECOND;
      end else if (esc_q == uqpd_pkg::ESC_SECOND) begin
        esc_d   = uqpd_pkg::ESC_IDLE;
        emit    = 1'b1;
        emit_ch = uqpd_pkg::esc_byte(first_q, s1_byte_q);
      end else begin
        started_d = 1'b1;
        unique case (s1_byte_q)
          uqpd_pkg::CH_AMP: begin
            pair_end = 1'b1;
            clear    = 1'b1;
          end
          uqpd_pkg::CH_EQ: begin
            if (!in_value_q) begin
              in_value_d = 1'b1;
            end else begin
              emit    = 1'b1;
              emit_ch = s1_byte_q;
            end
          end
          uqpd_pkg::CH_PLUS: begin
            emit    = 1'b1;
            emit_ch = uqpd_pkg::CH_SPACE;
          end
          uqpd_pkg::CH_PCT: begin
            esc_d = uqpd_pkg::ESC_FIRST;
          end
          default: begin
            emit    = 1'b1;
            emit_ch = s1_byte_q;
          end
        endcase
      end

      if (emit) begin
        if (!in_value_q) begin
          if (name_kept_q < name_limit_q) begin
            res_valid   = 1'b1;
            res_kind    = uqpd_pkg::KIND_NAME;
            res_char    = emit_ch;
            name_kept_d = name_kept_q + 8'd1;
          end else begin
            name_ovf_d = 1'b1;
          end
        end else begin
          if (value_kept_q < value_limit_q) begin
            res_valid    = 1'b1;
            res_kind     = uqpd_pkg::KIND_VALUE;
            res_char     = emit_ch;
            value_kept_d = value_kept_q + 8'd1;
          end else begin
            value_ovf_d = 1'b1;
          end
        end
      end

      if (pair_end) begin
        res_valid  = 1'b1;
        res_kind   = uqpd_pkg::KIND_PAIR_END;
        res_status = {value_ovf_q, name_ovf_q};
        res_ncnt   = name_kept_q;
        res_vcnt   = value_kept_q;
      end

      if (clear) begin
        in_value_d   = 1'b0;
        esc_d        = uqpd_pkg::ESC_IDLE;
        first_d      = 8'h00;
        name_kept_d  = 8'h00;
        value_kept_d = 8'h00;
        name_ovf_d   = 1'b0;
        value_ovf_d  = 1'b0;
        started_d    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      in_value_q   <= 1'b0;
      esc_q        <= uqpd_pkg::ESC_IDLE;
      first_q      <= 8'h00;
      name_kept_q  <= 8'h00;
      value_kept_q <= 8'h00;
      name_ovf_q   <= 1'b0;
      value_ovf_q  <= 1'b0;
      started_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      s1_valid_q   <= s1_valid_d;
      in_value_q   <= in_value_d;
      esc_q        <= esc_d;
      first_q      <= first_d;
      name_kept_q  <= name_kept_d;
      value_kept_q <= value_kept_d;
      name_ovf_q   <= name_ovf_d;
      value_ovf_q  <= value_ovf_d;
      started_q    <= started_d;
      if (s1_fire) begin
        out_valid_q <= res_valid;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && res_valid) begin
      out_kind_q   <= res_kind;
      out_char_q   <= res_char;
      out_status_q <= res_status;
      out_ncnt_q   <= res_ncnt;
      out_vcnt_q   <= res_vcnt;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.kind        = out_kind_q;
  assign out_o.char_out    = out_char_q;
  assign out_o.status      = out_status_q;
  assign out_o.name_count  = out_ncnt_q;
  assign out_o.value_count = out_vcnt_q;

  `ASSERT_IMP(a_idle_pair_clean, !started_q,
              name_kept_q == 8'h00 && value_kept_q == 8'h00 && !in_value_q &&
              !name_ovf_q && !value_ovf_q && esc_q == uqpd_pkg::ESC_IDLE,
              "pair state set before any pair byte")
  `ASSERT_IMP(a_ctrl_char_zero, out_valid_q && (out_kind_q == uqpd_pkg::KIND_PAIR_END ||
              out_kind_q == uqpd_pkg::KIND_EOS), out_char_q == 8'h00,
              "pair end or end of string carries a character")
  `ASSERT_NEVER(a_ready_when_empty, !s1_valid_q && !in_i.ready,
                "input stalled with empty input register")

endmodule
